### hdl/m3i_pkg.sv
// Shared types and constants for the 3x3 matrix inverse pipeline.
`timescale 1ns / 1ps

package m3i_pkg;

    localparam int DET_W  = 64;
    localparam int N_ELEM = 9;

    localparam logic [DET_W-1:0] DET_MAX = {1'b0, {(DET_W-1){1'b1}}};
    localparam logic [DET_W-1:0] DET_MIN = {1'b1, {(DET_W-1){1'b0}}};

    typedef logic [3:0] t_elem_idx;

    // Cofactor operands per adjugate entry: adj = e[a]*e[b] - e[c]*e[d].
    localparam t_elem_idx COF_TAB [N_ELEM][4] = '{
        '{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
        '{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd2, 4'd3, 4'd0, 4'd5},
        '{4'd3, 4'd7, 4'd4, 4'd6}, '{4'd1, 4'd6, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd1, 4'd3}
    };

    // Determinant result handed from the determinant unit to the divider lanes.
    typedef struct packed {
        logic [DET_W-1:0] det_bits;  // saturated determinant, Q format
        logic [DET_W-1:0] div_mag;   // divisor magnitude (one when singular)
        logic             singular;
    } t_det_info;

endpackage

### hdl/m3i_adj_lane.sv
// One adjugate lane: two cofactor products, then their exact difference.
`timescale 1ns / 1ps

module m3i_adj_lane #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [DATA_WIDTH-1:0]  i_a,
    input  logic signed [DATA_WIDTH-1:0]  i_b,
    input  logic signed [DATA_WIDTH-1:0]  i_c,
    input  logic signed [DATA_WIDTH-1:0]  i_d,
    output logic signed [2*DATA_WIDTH:0]  o_adj
);

    localparam int PW = 2 * DATA_WIDTH;

    logic signed [PW-1:0] r_p;
    logic signed [PW-1:0] r_q;
    logic signed [PW:0]   r_adj;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p   <= i_a * i_b;
            r_q   <= i_c * i_d;
            r_adj <= $signed({r_p[PW-1], r_p}) - $signed({r_q[PW-1], r_q});
        end
    end

    assign o_adj = r_adj;

endmodule

### hdl/m3i_det.sv
// Determinant unit: column-0 cofactor expansion, rescale, saturate, pick divisor.
`timescale 1ns / 1ps

module m3i_det #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [DATA_WIDTH-1:0]  i_elem [3],
    input  logic signed [2*DATA_WIDTH:0]  i_adj  [3],
    output m3i_pkg::t_det_info            o_det
);

    localparam int W  = DATA_WIDTH;
    localparam int PW = 2 * W;
    localparam int AW = 2 * W + 1;
    localparam int MW = 3 * W;
    localparam int SW = 3 * W + 3;
    localparam int XW = SW + m3i_pkg::DET_W + 1;

    logic [W-1:0]          w_emag [3];
    logic [PW-1:0]         w_amag [3];
    logic signed [W-1:0]   w_eneg [3];
    logic signed [AW-1:0]  w_aneg [3];
    logic [MW-1:0]         w_mag  [3];
    logic signed [SW-1:0]  w_mext [3];

    logic [PW-1:0]         r_lo   [3];
    logic [PW-1:0]         r_hi   [3];
    logic                  r_sgn  [3];
    logic signed [SW-1:0]  r_prod [3];
    logic signed [SW-1:0]  r_d3;
    m3i_pkg::t_det_info    r_det;

    logic                  w_dneg;
    logic signed [SW-1:0]  w_dneg_v;
    logic [SW-1:0]         w_dabs;
    logic [XW-1:0]         w_sh;
    logic                  w_sat;
    logic [m3i_pkg::DET_W-2:0] w_low;
    m3i_pkg::t_det_info    w_det;

    // Magnitudes of the expansion operands; split the adjugate into halves.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_eneg[k] = -i_elem[k];
            w_aneg[k] = -i_adj[k];
            w_emag[k] = i_elem[k][W-1] ? w_eneg[k] : i_elem[k];
            w_amag[k] = i_adj[k][AW-1] ? w_aneg[k][PW-1:0] : i_adj[k][PW-1:0];
            w_mag[k]  = {r_hi[k], {W{1'b0}}} + {{W{1'b0}}, r_lo[k]};
            w_mext[k] = $signed({3'b000, w_mag[k]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_lo[k]   <= w_emag[k] * w_amag[k][W-1:0];
                r_hi[k]   <= w_emag[k] * w_amag[k][PW-1:W];
                r_sgn[k]  <= i_elem[k][W-1] ^ i_adj[k][AW-1];
                r_prod[k] <= r_sgn[k] ? -w_mext[k] : w_mext[k];
            end
            r_d3  <= r_prod[0] + r_prod[1] + r_prod[2];
            r_det <= w_det;
        end
    end

    // Truncate toward zero by 2F bits, saturate to 64 bits, pick the divisor.
    always_comb begin
        w_dneg   = r_d3[SW-1];
        w_dneg_v = -r_d3;
        w_dabs   = w_dneg ? w_dneg_v : r_d3;
        w_sh     = {{(XW-SW){1'b0}}, w_dabs} >> (2 * FRAC_BITS);
        w_sat    = |w_sh[XW-1:m3i_pkg::DET_W-1];
        w_low    = w_sh[m3i_pkg::DET_W-2:0];
        if (w_sat) begin
            w_det.det_bits = w_dneg ? m3i_pkg::DET_MIN : m3i_pkg::DET_MAX;
            w_det.div_mag  = w_dneg ? m3i_pkg::DET_MIN : m3i_pkg::DET_MAX;
            w_det.singular = 1'b0;
        end else begin
            w_det.det_bits = w_dneg ? -{1'b0, w_low} : {1'b0, w_low};
            w_det.singular = (w_low == '0);
            w_det.div_mag  = w_det.singular ? (m3i_pkg::DET_W'(1) << FRAC_BITS)
                                            : {1'b0, w_low};
        end
    end

    assign o_det = r_det;

endmodule

### hdl/m3i_div_lane.sv
// Divider lane: one quotient bit per stage, saturating signed result.
`timescale 1ns / 1ps

module m3i_div_lane #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [2*DATA_WIDTH:0]  i_adj,
    input  m3i_pkg::t_det_info            i_det,
    output logic signed [DATA_WIDTH-1:0]  o_quot
);

    localparam int W  = DATA_WIDTH;
    localparam int PW = 2 * W;
    localparam int AW = 2 * W + 1;
    localparam int DW = m3i_pkg::DET_W;
    localparam int RW = DW + W;
    localparam int NB = W - 1;

    logic signed [AW-1:0] w_aneg;
    logic [PW-1:0]        w_amag;
    logic                 w_sat;

    logic [PW-1:0]  r_rem [NB+1];
    logic [NB-1:0]  r_q   [NB+1];
    logic [DW-1:0]  r_div [NB+1];
    logic           r_neg [NB+1];
    logic           r_sat [NB+1];
    logic signed [W-1:0] r_quot;

    // Quotient saturates when |adj| >= divisor * 2^(W-1).
    always_comb begin
        w_aneg = -i_adj;
        w_amag = i_adj[AW-1] ? w_aneg[PW-1:0] : i_adj[PW-1:0];
        w_sat  = {{(RW-PW){1'b0}}, w_amag} >= ({{W{1'b0}}, i_det.div_mag} << NB);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= w_amag;
            r_q[0]   <= '0;
            r_div[0] <= i_det.div_mag;
            r_neg[0] <= i_adj[AW-1] ^ i_det.det_bits[DW-1];
            r_sat[0] <= w_sat;
        end
    end

    for (genvar j = 0; j < NB; j++) begin : g_step
        localparam int B = NB - 1 - j;
        logic [RW-1:0] w_dsh;
        logic [RW-1:0] w_rext;
        logic [RW-1:0] w_diff;
        logic          w_ge;

        always_comb begin
            w_dsh  = {{W{1'b0}}, r_div[j]} << B;
            w_rext = {{(RW-PW){1'b0}}, r_rem[j]};
            w_diff = w_rext - w_dsh;
            w_ge   = w_rext >= w_dsh;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j+1]    <= w_ge ? w_diff[PW-1:0] : r_rem[j];
                r_q[j+1]      <= r_q[j] | ({{(NB-1){1'b0}}, w_ge} << B);
                r_div[j+1]    <= r_div[j];
                r_neg[j+1]    <= r_neg[j];
                r_sat[j+1]    <= r_sat[j];
            end
        end
    end

    // Apply sign, or clamp to the signed range.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_sat[NB]) begin
                r_quot <= r_neg[NB] ? {1'b1, {NB{1'b0}}} : {1'b0, {NB{1'b1}}};
            end else begin
                r_quot <= r_neg[NB] ? -$signed({1'b0, r_q[NB]}) : $signed({1'b0, r_q[NB]});
            end
        end
    end

    assign o_quot = r_quot;

endmodule

### hdl/matrix3_inverse_top.sv
// Top level of the 3x3 matrix inverse: adjugate lanes, determinant, divider lanes.
`timescale 1ns / 1ps

// Usage
//   Slave stream carries one 3x3 matrix per transfer: nine signed
//   fixed-point elements (DATA_WIDTH bits, FRAC_BITS fractional bits).
//   Master stream returns one result per matrix: the nine inverse elements,
//   the 64-bit saturated determinant and, in tuser, the singular flag.
//   A zero determinant is replaced by one, so the adjugate comes out and the
//   flag is set.
// Throughput
//   The pipeline takes one matrix per cycle while the skid register is empty;
//   its depth is set by the divider lanes, which resolve one quotient bit
//   per stage, nine lanes side by side.
// Reset
//   i_rst_n low clears every stage valid and the skid stage; data in flight
//   is dropped.
// Stall
//   When the receiver holds off, the result at the pipeline end moves into a
//   skid register and the pipeline takes one more matrix; then o_s_tready
//   drops and the whole pipeline holds until the skid result is taken.
module matrix3_inverse_top #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // a00, a01, a02, a10, a11, a12, a20, a21, a22 (lowest first), zero pad
    input  logic [((m3i_pkg::N_ELEM * DATA_WIDTH + 7) / 8) * 8 - 1:0] i_s_tdata,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // inv00 .. inv22, det_value (lowest first), zero pad
    output logic [((m3i_pkg::N_ELEM * DATA_WIDTH + m3i_pkg::DET_W + 7) / 8) * 8 - 1:0]
                                 o_m_tdata,
    // singular
    output logic                 o_m_tuser
);

    localparam int W     = DATA_WIDTH;
    localparam int NE    = m3i_pkg::N_ELEM;
    localparam int DW    = m3i_pkg::DET_W;
    localparam int OUT_W = ((NE * W + DW + 7) / 8) * 8;
    localparam int NS    = W + 7;   // pipeline depth, stage NS is the last

    logic                   w_en;
    logic [NS:1]            r_valid;

    logic signed [W-1:0]    w_elem [NE];
    logic signed [W-1:0]    r_e1 [3];
    logic signed [W-1:0]    r_e2 [3];
    logic signed [2*W:0]    w_adj [NE];
    logic signed [2*W:0]    r_adj_p [NE][4];
    logic signed [W-1:0]    w_quot [NE];
    m3i_pkg::t_det_info     w_det;
    logic [DW-1:0]          r_det_p [W+1];
    logic                   r_sing_p [W+1];

    logic [OUT_W-1:0]       w_out_data;
    logic                   r_skid_v;
    logic [OUT_W-1:0]       r_skid_data;
    logic                   r_skid_user;

    // Advance everything unless the skid stage holds a result.
    assign w_en       = !r_skid_v;
    assign o_s_tready = w_en;

    always_comb begin
        for (int k = 0; k < NE; k++) begin
            w_elem[k] = i_s_tdata[k*W +: W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_en) begin
            r_valid <= {r_valid[NS-1:1], i_s_tvalid};
        end
    end

    // Column-0 elements follow the adjugate lanes to the determinant unit.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_e1[k] <= w_elem[3*k];
                r_e2[k] <= r_e1[k];
            end
        end
    end

    for (genvar i = 0; i < NE; i++) begin : g_adj
        m3i_adj_lane #(.DATA_WIDTH(W)) u_adj (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_a   (w_elem[m3i_pkg::COF_TAB[i][0]]),
            .i_b   (w_elem[m3i_pkg::COF_TAB[i][1]]),
            .i_c   (w_elem[m3i_pkg::COF_TAB[i][2]]),
            .i_d   (w_elem[m3i_pkg::COF_TAB[i][3]]),
            .o_adj (w_adj[i])
        );

        // Delay the adjugate entry while the determinant is formed.
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_adj_p[i][0] <= w_adj[i];
                for (int s = 1; s < 4; s++) begin
                    r_adj_p[i][s] <= r_adj_p[i][s-1];
                end
            end
        end

        m3i_div_lane #(.DATA_WIDTH(W)) u_div (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_adj  (r_adj_p[i][3]),
            .i_det  (w_det),
            .o_quot (w_quot[i])
        );
    end

    m3i_det #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_det (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_elem (r_e2),
        .i_adj  (w_adj[0:2]),
        .o_det  (w_det)
    );

    // Carry determinant and flag alongside the divider stages.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_det_p[0]  <= w_det.det_bits;
            r_sing_p[0] <= w_det.singular;
            for (int s = 1; s <= W; s++) begin
                r_det_p[s]  <= r_det_p[s-1];
                r_sing_p[s] <= r_sing_p[s-1];
            end
        end
    end

    always_comb begin
        w_out_data = '0;
        for (int k = 0; k < NE; k++) begin
            w_out_data[k*W +: W] = w_quot[k];
        end
        w_out_data[NE*W +: DW] = r_det_p[W];
    end

    // Skid stage: catch the last-stage result when the receiver stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (i_m_tready) begin
                r_skid_v <= 1'b0;
            end
        end else if (r_valid[NS] && !i_m_tready) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_v && r_valid[NS] && !i_m_tready) begin
            r_skid_data <= w_out_data;
            r_skid_user <= r_sing_p[W];
        end
    end

    assign o_m_tvalid = r_skid_v || r_valid[NS];
    assign o_m_tdata  = r_skid_v ? r_skid_data : w_out_data;
    assign o_m_tuser  = r_skid_v ? r_skid_user : r_sing_p[W];

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid[NS] && !r_skid_v && !i_m_tready) |=> r_skid_v)
        else $error("stalled result not caught by skid stage");

    a_skid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && !i_m_tready) |=> (r_skid_v && $stable(r_skid_data)))
        else $error("skid result lost or changed while stalled");

    a_pipe_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |=> $stable(r_valid))
        else $error("pipeline moved while skid stage was full");

    a_singular: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser == (o_m_tdata[NE*W +: DW] == '0)))
        else $error("singular flag disagrees with determinant");

endmodule
